>>> rtl/core/rgb565_pixel_blend_top_defines.svh
// assertion macros used by the blend core
`ifndef RGB565_PIXEL_BLEND_TOP_DEFINES_SVH
`define RGB565_PIXEL_BLEND_TOP_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define RPB_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rpb assertion failed");

// antecedent holds, consequent holds in the next cycle
`define RPB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rpb assertion failed");

`endif

>>> rtl/core/rpb_pkg.sv
package rpb_pkg;

   localparam int PIXEL_W   = 16;
   localparam int CHAN_W    = 8;
   localparam int ARGB_W    = 32;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_ARGB = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE  = 1'b1;

   localparam logic [MODE_W-1:0] MODE_MIX_BIT    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_INVMUL_BIT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ADD_BIT    = 3'd1;

   // reciprocal multipliers: v*255/31, v*255/63, x/255, c*31/255, c*63/255
   localparam logic [21:0] EXP5_MUL = 22'd2156535;   // 255*8457, shift 18
   localparam logic [22:0] EXP6_MUL = 23'd4244475;   // 255*16645, shift 20
   localparam logic [15:0] DIV255_MUL = 16'd32897;   // shift 23
   localparam logic [19:0] PACK5_MUL = 20'd1019807;  // 31*32897, shift 23
   localparam logic [20:0] PACK6_MUL = 21'd2072511;  // 63*32897, shift 23

   typedef logic [CHAN_W-1:0] chan_type;

   typedef enum logic [1:0] {
      LAW_REPLACE,
      LAW_ADD,
      LAW_INVMUL,
      LAW_MIX
   } law_type;

   typedef struct packed {
      logic [ARGB_W-1:0] source_argb;
      logic [MODE_W-1:0] blend_mode;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [PIXEL_W-1:0]   pixel;
   } pix_stage_type;

   typedef struct packed {
      logic                 valid;
      chan_type [2:0]       chan;
   } rgb_stage_type;

   function automatic law_type decode_law(logic [MODE_W-1:0] mode);
      law_type law;
      if ((mode & MODE_MIX_BIT) != '0) begin
         law = LAW_MIX;
      end else if ((mode & MODE_INVMUL_BIT) != '0) begin
         law = LAW_INVMUL;
      end else if ((mode & MODE_ADD_BIT) != '0) begin
         law = LAW_ADD;
      end else begin
         law = LAW_REPLACE;
      end
      return law;
   endfunction

endpackage

>>> rtl/core/rpb_req_if.sv
interface rpb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] dest_pixel;

   modport source (output valid, output dest_pixel, input ready);
   modport sink (input valid, input dest_pixel, output ready);
endinterface

>>> rtl/core/rpb_rsp_if.sv
interface rpb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] blended_pixel;

   modport source (output valid, output blended_pixel, input ready);
   modport sink (input valid, input blended_pixel, output ready);
endinterface

>>> rtl/core/rgb565_pixel_blend_top.sv
// rgb565 pixel blend core
// req_chan carries one destination pixel (RGB565) per beat; rsp_chan returns
// the blended pixel for each, in order, one result beat per request beat.
// the source colour and blend mode are set through the csr write port:
// index 0 source_argb, index 1 blend_mode; write only while the core is idle.
// path: each request beat is registered in turn by the expand, products,
// divide and pack stages before its result beat is valid on rsp_chan.
// throughput: one pixel per cycle; every stage is a register with its own
// valid bit, so a new beat is taken every cycle while the pipe flows.
// stall: when rsp_chan.ready is low the result is held and the stages behind
// it keep filling any bubbles; req_chan.ready drops only once all four
// stages hold a pixel. nothing is lost or repeated.
// reset: synchronous, active high; empties the pipe and clears both csr
// registers to zero (replace mode, black transparent source).
`include "rgb565_pixel_blend_top_defines.svh"

module rgb565_pixel_blend_top (
   input  logic                         clock,
   input  logic                         reset,
   rpb_req_if.sink                      req_chan,
   rpb_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [rpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rpb_pkg::ARGB_W-1:0]   csr_wdata
);
   import rpb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   pix_stage_type req_stage;
   rgb_stage_type exp_stage;
   rgb_stage_type mix_stage;
   pix_stage_type pack_stage;
   logic          exp_ready;
   logic          mix_ready;
   logic          pack_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_ARGB: cfg_in.source_argb = csr_wdata;
            CSR_BLEND_MODE:  cfg_in.blend_mode  = csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stage.valid = req_chan.valid;
   assign req_stage.pixel = req_chan.dest_pixel;

   rpb_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (req_stage),
      .in_ready  (req_chan.ready),
      .out_stage (exp_stage),
      .out_ready (exp_ready)
   );

   rpb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_stage  (exp_stage),
      .in_ready  (exp_ready),
      .out_stage (mix_stage),
      .out_ready (mix_ready)
   );

   rpb_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (mix_stage),
      .in_ready  (mix_ready),
      .out_stage (pack_stage),
      .out_ready (pack_ready)
   );

   assign pack_ready             = rsp_chan.ready;
   assign rsp_chan.valid         = pack_stage.valid;
   assign rsp_chan.blended_pixel = pack_stage.pixel;

   // an empty output stage means no stage can be blocking the input
   `RPB_ASSERT_SAME(a_ready_when_out_empty, !rsp_chan.valid, req_chan.ready)
   // full white channels pack to full white
   `RPB_ASSERT_NEXT(a_white_packs_white,
      mix_stage.valid && mix_ready && (mix_stage.chan == {3{8'hFF}}),
      rsp_chan.blended_pixel == 16'hFFFF)
   // a held beat inside the pipe keeps its channels
   `RPB_ASSERT_NEXT(a_mix_holds_on_stall, mix_stage.valid && !mix_ready,
      mix_stage.valid && $stable(mix_stage.chan))

endmodule

>>> rtl/core/rpb_expand.sv
module rpb_expand (
   input  logic                   clock,
   input  logic                   reset,
   input  rpb_pkg::pix_stage_type in_stage,
   output logic                   in_ready,
   output rpb_pkg::rgb_stage_type out_stage,
   input  logic                   out_ready
);
   import rpb_pkg::*;

   rgb_stage_type stage_ff;
   rgb_stage_type stage_in;
   logic          advance;
   logic [26:0]   r_prod;
   logic [28:0]   g_prod;
   logic [26:0]   b_prod;

   assign advance  = !stage_ff.valid || out_ready;
   assign in_ready = advance;

   // widen each channel to 8 bits
   always_comb begin
      r_prod = 27'(in_stage.pixel[15:11]) * 27'(EXP5_MUL);
      g_prod = 29'(in_stage.pixel[10:5]) * 29'(EXP6_MUL);
      b_prod = 27'(in_stage.pixel[4:0]) * 27'(EXP5_MUL);
      stage_in.valid   = in_stage.valid;
      stage_in.chan[2] = r_prod[25:18];
      stage_in.chan[1] = g_prod[27:20];
      stage_in.chan[0] = b_prod[25:18];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.chan <= stage_in.chan;
      end
   end

   assign out_stage = stage_ff;

endmodule

>>> rtl/core/rpb_mix.sv
module rpb_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  rpb_pkg::cfg_type       cfg,
   input  rpb_pkg::rgb_stage_type in_stage,
   output logic                   in_ready,
   output rpb_pkg::rgb_stage_type out_stage,
   input  logic                   out_ready
);
   import rpb_pkg::*;

   // products stage
   logic             prod_valid_ff;
   law_type          prod_law_ff;
   logic [15:0]      prod_ff [3];
   law_type          prod_law_in;
   logic [15:0]      prod_in [3];
   logic             prod_advance;

   // divide stage
   rgb_stage_type    div_ff;
   chan_type         div_in [3];
   logic             div_advance;
   logic [31:0]      div_prod [3];

   chan_type         alpha;
   chan_type         src [3];
   chan_type         inv_alpha;
   chan_type         inv_src [3];

   assign alpha  = cfg.source_argb[31:24];
   assign src[2] = cfg.source_argb[23:16];
   assign src[1] = cfg.source_argb[15:8];
   assign src[0] = cfg.source_argb[7:0];

   // 255 minus the value, kept at 8 bits
   assign inv_alpha  = ~alpha;
   assign inv_src[2] = ~src[2];
   assign inv_src[1] = ~src[1];
   assign inv_src[0] = ~src[0];

   assign div_advance  = !div_ff.valid || out_ready;
   assign prod_advance = !prod_valid_ff || div_advance;
   assign in_ready     = prod_advance;

   always_comb begin
      prod_law_in = decode_law(cfg.blend_mode);
      for (int i = 0; i < 3; i++) begin
         case (prod_law_in)
            LAW_MIX: begin
               prod_in[i] = 16'(src[i]) * 16'(inv_alpha) + 16'(in_stage.chan[i]) * 16'(alpha);
            end
            LAW_INVMUL: begin
               prod_in[i] = 16'(in_stage.chan[i]) * 16'(inv_src[i]);
            end
            LAW_ADD: begin
               prod_in[i] = 16'(in_stage.chan[i]) + 16'(src[i]);
            end
            default: begin
               prod_in[i] = 16'(src[i]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_advance) begin
         prod_valid_ff <= in_stage.valid;
      end
      if (prod_advance) begin
         prod_law_ff <= prod_law_in;
         prod_ff     <= prod_in;
      end
   end

   // divide by 255 through a reciprocal, saturate the sum, or pass the source through
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_prod[i] = 32'(prod_ff[i]) * 32'(DIV255_MUL);
         case (prod_law_ff)
            LAW_MIX, LAW_INVMUL: begin
               div_in[i] = div_prod[i][30:23];
            end
            LAW_ADD: begin
               div_in[i] = (prod_ff[i] > 16'd255) ? 8'd255 : prod_ff[i][7:0];
            end
            default: begin
               div_in[i] = prod_ff[i][7:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (div_advance) begin
         div_ff.valid <= prod_valid_ff;
      end
      if (div_advance) begin
         div_ff.chan[2] <= div_in[2];
         div_ff.chan[1] <= div_in[1];
         div_ff.chan[0] <= div_in[0];
      end
   end

   assign out_stage = div_ff;

endmodule

>>> rtl/core/rpb_pack.sv
module rpb_pack (
   input  logic                   clock,
   input  logic                   reset,
   input  rpb_pkg::rgb_stage_type in_stage,
   output logic                   in_ready,
   output rpb_pkg::pix_stage_type out_stage,
   input  logic                   out_ready
);
   import rpb_pkg::*;

   pix_stage_type stage_ff;
   pix_stage_type stage_in;
   logic          advance;
   logic [27:0]   r_prod;
   logic [28:0]   g_prod;
   logic [27:0]   b_prod;

   assign advance  = !stage_ff.valid || out_ready;
   assign in_ready = advance;

   // narrow back to 5-6-5
   always_comb begin
      r_prod = 28'(in_stage.chan[2]) * 28'(PACK5_MUL);
      g_prod = 29'(in_stage.chan[1]) * 29'(PACK6_MUL);
      b_prod = 28'(in_stage.chan[0]) * 28'(PACK5_MUL);
      stage_in.valid = in_stage.valid;
      stage_in.pixel = {r_prod[27:23], g_prod[28:23], b_prod[27:23]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.pixel <= stage_in.pixel;
      end
   end

   assign out_stage = stage_ff;

endmodule
